// ===== hdl/assert_macros.svh =====
// Assertion helpers used by stq_dpath. Clock is clk, reset is rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/stq_pkg.sv =====
package stq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TICK_WIDTH_DEF  = 32;
    localparam int TAG_W           = 16;
    localparam int DELAY_W         = 31;
    localparam int MAX_REPORTS     = 16;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FLUSH,
        ST_INS_RD,
        ST_INS_CHK,
        ST_ACK
    } stq_state_t;

    typedef struct packed {
        logic take;       // latch input word
        logic rd_head;    // read head entry
        logic pop_hold;   // pop head into held report
        logic push_held;  // send held report
        logic push_last;  // held report is the final one
        logic rd_ins;     // read entry below insert slot
        logic wr_shift;   // move read entry up one slot
        logic wr_new;     // write new entry into slot
        logic push_ack;   // send set acknowledgement
    } stq_cmd_t;

    typedef struct packed {
        logic full;
        logic can_scan;
        logic reached;
        logic held_valid;
        logic out_free;
        logic idx_zero;
        logic later;
    } stq_status_t;

endpackage

// ===== hdl/sorted_timeout_queue.sv =====
// Sorted timeout queue: one word at a time, accepted only when the controller is idle.
// Set: entries are read from the tail and each later one moves up a slot; then the new
// entry is written and the ack is sent. A set on a full queue goes straight to the ack.
// Tick: reached head entries are popped and reported, at most 16 expiries per tick, the
// last flagged. Output stalls hold the FSM; the result register lets the next word in.
// Reset (async, active low) clears the tick counter, queue count, head and valid flags.
module sorted_timeout_queue #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF,
    parameter int TICK_WIDTH  = stq_pkg::TICK_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        cmd,
    input  logic [stq_pkg::DELAY_W-1:0] delay,
    input  logic [stq_pkg::TAG_W-1:0]   tag,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [stq_pkg::TAG_W-1:0]   fired_tag,
    output logic                        status,
    output logic                        last
);
    import stq_pkg::*;

    stq_cmd_t    ctl;
    stq_status_t stat;
    logic        ready;

    assign in_stall = !ready;

    stq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (cmd),
        .stat     (stat),
        .ready    (ready),
        .ctl      (ctl)
    );

    stq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICK_WIDTH  (TICK_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .cmd       (cmd),
        .delay     (delay),
        .tag       (tag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .fired_tag (fired_tag),
        .status    (status),
        .last      (last)
    );

endmodule

// ===== hdl/stq_ctrl.sv =====
module stq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_cmd,
    input  stq_pkg::stq_status_t stat,
    output logic                 ready,
    output stq_pkg::stq_cmd_t    ctl
);
    import stq_pkg::*;

    stq_state_t state_reg;
    stq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (in_valid)
                begin
                    ctl.take = 1'b1;
                    if (in_cmd == CMD_SET)
                    begin
                        state_next = stat.full ? ST_ACK : ST_INS_RD;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                if (stat.can_scan)
                begin
                    ctl.rd_head = 1'b1;
                    state_next  = ST_SCAN_CHK;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_SCAN_CHK:
            begin
                if (!stat.reached)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!stat.held_valid || stat.out_free)
                begin
                    // earlier report is known not to be last now
                    ctl.push_held = stat.held_valid;
                    ctl.pop_hold  = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.held_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    ctl.push_held = 1'b1;
                    ctl.push_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_INS_RD:
            begin
                if (stat.idx_zero)
                begin
                    ctl.wr_new = 1'b1;
                    state_next = ST_ACK;
                end
                else
                begin
                    ctl.rd_ins = 1'b1;
                    state_next = ST_INS_CHK;
                end
            end
            ST_INS_CHK:
            begin
                if (stat.later)
                begin
                    ctl.wr_shift = 1'b1;
                    state_next   = ST_INS_RD;
                end
                else
                begin
                    ctl.wr_new = 1'b1;
                    state_next = ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (stat.out_free)
                begin
                    ctl.push_ack = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/stq_dpath.sv =====
`include "assert_macros.svh"

module stq_dpath #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF,
    parameter int TICK_WIDTH  = stq_pkg::TICK_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stq_pkg::stq_cmd_t           ctl,
    output stq_pkg::stq_status_t        stat,
    input  logic                        cmd,
    input  logic [stq_pkg::DELAY_W-1:0] delay,
    input  logic [stq_pkg::TAG_W-1:0]   tag,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [stq_pkg::TAG_W-1:0]   fired_tag,
    output logic                        status,
    output logic                        last
);
    import stq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = $clog2(MAX_REPORTS + 1);
    localparam int EW = TICK_WIDTH + TAG_W;
    localparam logic [IW:0]   QD_W  = (IW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] QD_C  = CW'(QUEUE_DEPTH);
    localparam logic [RW-1:0] MAX_R = RW'(MAX_REPORTS);

    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic [EW-1:0] rd_reg;

    logic [TICK_WIDTH-1:0] now_reg, now_next;
    logic [IW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [RW-1:0]         nrep_reg, nrep_next;
    logic                  held_valid_reg, held_valid_next;
    logic [TAG_W-1:0]      held_tag_reg, held_tag_next;
    logic [TICK_WIDTH-1:0] new_dl_reg, new_dl_next;
    logic [TAG_W-1:0]      new_tag_reg, new_tag_next;
    logic                  drop_reg, drop_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  kind_reg, kind_next;
    logic [TAG_W-1:0]      fired_tag_reg, fired_tag_next;
    logic                  status_reg, status_next;
    logic                  last_reg, last_next;

    logic [63:0]           delay_wide;
    logic [TICK_WIDTH-1:0] delay_ext;
    logic [TICK_WIDTH-1:0] rd_dl;
    logic [TAG_W-1:0]      rd_tag;
    logic [TICK_WIDTH-1:0] later_diff;
    logic [TICK_WIDTH-1:0] reach_diff;
    logic                  out_free;
    logic                  mem_we;
    logic                  mem_re;
    logic [IW-1:0]         wr_addr;
    logic [IW-1:0]         rd_addr;
    logic [EW-1:0]         wr_data;

    function automatic logic [IW-1:0] wrap_idx(input logic [IW-1:0] base,
                                               input logic [IW-1:0] off);
        logic [IW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= QD_W)
        begin
            s = s - QD_W;
        end
        return s[IW-1:0];
    endfunction

    assign delay_wide = 64'(delay);
    assign delay_ext  = delay_wide[TICK_WIDTH-1:0];

    assign rd_dl  = rd_reg[EW-1:TAG_W];
    assign rd_tag = rd_reg[TAG_W-1:0];

    // modular distance: later when nonzero and top bit clear
    assign later_diff = rd_dl - new_dl_reg;
    assign reach_diff = now_reg - rd_dl;

    assign out_free = !out_valid_reg || !out_stall;

    assign stat.full       = (count_reg == QD_C);
    assign stat.can_scan   = (nrep_reg < MAX_R) && (count_reg != '0);
    assign stat.reached    = !reach_diff[TICK_WIDTH-1];
    assign stat.held_valid = held_valid_reg;
    assign stat.out_free   = out_free;
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.later      = (later_diff != '0) && !later_diff[TICK_WIDTH-1];

    assign mem_we  = ctl.wr_new || ctl.wr_shift;
    assign mem_re  = ctl.rd_head || ctl.rd_ins;
    assign wr_addr = wrap_idx(head_reg, idx_reg);
    assign rd_addr = ctl.rd_ins ? wrap_idx(head_reg, idx_reg - 1'b1) : head_reg;
    assign wr_data = ctl.wr_shift ? rd_reg : {new_dl_reg, new_tag_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        now_next        = now_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        nrep_next       = nrep_reg;
        held_valid_next = held_valid_reg;
        held_tag_next   = held_tag_reg;
        new_dl_next     = new_dl_reg;
        new_tag_next    = new_tag_reg;
        drop_next       = drop_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        fired_tag_next  = fired_tag_reg;
        status_next     = status_reg;
        last_next       = last_reg;

        if (ctl.take)
        begin
            if (cmd == CMD_SET)
            begin
                new_dl_next  = now_reg + delay_ext;
                new_tag_next = tag;
                drop_next    = (count_reg == QD_C);
                idx_next     = count_reg[IW-1:0];
            end
            else
            begin
                now_next        = now_reg + 1'b1;
                nrep_next       = '0;
                held_valid_next = 1'b0;
            end
        end

        if (ctl.pop_hold)
        begin
            held_valid_next = 1'b1;
            held_tag_next   = rd_tag;
            head_next       = wrap_idx(head_reg, IW'(1));
            count_next      = count_reg - 1'b1;
            nrep_next       = RW'(nrep_reg + 1'b1);
        end
        else if (ctl.push_held)
        begin
            held_valid_next = 1'b0;
        end

        if (ctl.wr_shift)
        begin
            idx_next = idx_reg - 1'b1;
        end

        if (ctl.push_held)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_EXPIRY;
            fired_tag_next = held_tag_reg;
            status_next    = STATUS_OK;
            last_next      = ctl.push_last;
        end
        else if (ctl.push_ack)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_ACK;
            fired_tag_next = '0;
            status_next    = drop_reg ? STATUS_FULL : STATUS_OK;
            last_next      = 1'b1;
            if (!drop_reg)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            now_reg        <= now_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        nrep_reg      <= nrep_next;
        held_tag_reg  <= held_tag_next;
        new_dl_reg    <= new_dl_next;
        new_tag_reg   <= new_tag_next;
        drop_reg      <= drop_next;
        kind_reg      <= kind_next;
        fired_tag_reg <= fired_tag_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign fired_tag = fired_tag_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    `ASSERT_IMPL(a_push_when_free, ctl.push_held || ctl.push_ack, out_free)
    `ASSERT_IMPL(a_no_pop_empty, ctl.pop_hold, count_reg != '0)
    `ASSERT_IMPL(a_no_insert_full, ctl.wr_new, count_reg < QD_C)
    `ASSERT_NEXT(a_tick_advances, ctl.take && cmd == CMD_TICK,
                 now_reg == TICK_WIDTH'($past(now_reg) + 1'b1))

endmodule

// ===== verif/stq_checker.sv =====
`timescale 1ns / 100ps
module stq_checker
    import stq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               cmd,
    input  logic [DELAY_W-1:0] delay,
    input  logic [TAG_W-1:0]   tag,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               kind,
    input  logic [TAG_W-1:0]   fired_tag,
    input  logic               status,
    input  logic               last,
    output int                 fail_count,
    output int                 awaited
);

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int TW    = TICK_WIDTH_DEF;

    typedef struct packed {
        logic             kind;
        logic [TAG_W-1:0] tag;
        logic             status;
        logic             last;
    } report_t;

    report_t          due_reports[$];
    logic [TW-1:0]    now_ticks;
    logic [TW-1:0]    deadline_mem[DEPTH];
    logic [TAG_W-1:0] tag_mem[DEPTH];
    int               pending;

    function automatic logic is_later(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW-1:0] diff;
        begin
            diff = a - b;
            return (diff != '0) && !diff[TW-1];
        end
    endfunction

    function automatic logic is_reached(input logic [TW-1:0] now, input logic [TW-1:0] dl);
        logic [TW-1:0] diff;
        begin
            diff = now - dl;
            return !diff[TW-1];
        end
    endfunction

    task automatic timer_set(input logic [DELAY_W-1:0] d, input logic [TAG_W-1:0] t);
        logic [TW-1:0] dl;
        int            pos;
        report_t       ack;
        begin
            ack.kind = KIND_ACK;
            ack.tag = '0;
            ack.last = 1'b1;
            if (pending >= DEPTH) begin
                ack.status = STATUS_FULL;
            end
            else begin
                ack.status = STATUS_OK;
                dl = now_ticks + TW'(d);
                pos = 0;
                // equal deadlines keep arrival order
                while (pos < pending && !is_later(deadline_mem[pos], dl))
                    pos++;
                for (int j = pending; j > pos; j--)
                begin
                    deadline_mem[j] = deadline_mem[j-1];
                    tag_mem[j] = tag_mem[j-1];
                end
                deadline_mem[pos] = dl;
                tag_mem[pos] = t;
                pending++;
            end
            due_reports.push_back(ack);
        end
    endtask

    task automatic timer_tick();
        int      n;
        report_t rep;
        begin
            now_ticks = now_ticks + 1'b1;
            n = 0;
            while (n < MAX_REPORTS && n < pending && is_reached(now_ticks, deadline_mem[n]))
                n++;
            for (int i = 0; i < n; i++)
            begin
                rep.kind = KIND_EXPIRY;
                rep.tag = tag_mem[i];
                rep.status = STATUS_OK;
                rep.last = (i == n - 1);
                due_reports.push_back(rep);
            end
            for (int j = n; j < pending; j++)
            begin
                deadline_mem[j-n] = deadline_mem[j];
                tag_mem[j-n] = tag_mem[j];
            end
            pending -= n;
        end
    endtask

    task automatic note_error(input report_t want, input logic have_want);
        begin
            fail_count++;
            if (fail_count <= 10) begin
                if (have_want)
                    $display("%0t: result mismatch: expected kind=%0d tag=%h status=%0d last=%0d, got kind=%0d tag=%h status=%0d last=%0d",
                             $time, want.kind, want.tag, want.status, want.last,
                             kind, fired_tag, status, last);
                else
                    $display("%0t: unexpected result: kind=%0d tag=%h status=%0d last=%0d",
                             $time, kind, fired_tag, status, last);
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        awaited = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        if (!rst_n) begin
            due_reports.delete();
            now_ticks = '0;
            pending = 0;
            awaited = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (due_reports.size() == 0) begin
                    want = '0;
                    note_error(want, 1'b0);
                end
                else begin
                    want = due_reports.pop_front();
                    if (want.kind !== kind || want.tag !== fired_tag ||
                        want.status !== status || want.last !== last)
                        note_error(want, 1'b1);
                end
            end
            if (in_valid && !in_stall) begin
                if (cmd == CMD_SET)
                    timer_set(delay, tag);
                else
                    timer_tick();
            end
            awaited = due_reports.size();
        end
    end

endmodule

// ===== verif/sorted_timeout_queue_tb.sv =====
`timescale 1ns / 100ps
module sorted_timeout_queue_tb;
    import stq_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               cmd;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   tag;
    logic               out_valid;
    logic               out_stall;
    logic               kind;
    logic [TAG_W-1:0]   fired_tag;
    logic               status;
    logic               last;

    int fail_count;
    int awaited;
    int gap_pct;
    int stall_pct;
    int set_pct;
    int long_delays;
    bit calm;

    sorted_timeout_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .delay     (delay),
        .tag       (tag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .fired_tag (fired_tag),
        .status    (status),
        .last      (last)
    );

    stq_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .delay      (delay),
        .tag        (tag),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .fired_tag  (fired_tag),
        .status     (status),
        .last       (last),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: random stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && rst_n && stall_left == 0 && $urandom_range(99) < stall_pct)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic c, input logic [DELAY_W-1:0] d,
                             input logic [TAG_W-1:0] t);
        int gap;
        begin
            if (!calm && $urandom_range(99) < gap_pct) begin
                gap = $urandom_range(1, 5);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            cmd <= c;
            delay <= d;
            tag <= t;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic drain();
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (awaited != 0) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [DELAY_W-1:0] d;
        int                 sel;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_TICK;
        delay = '0;
        tag = '0;
        gap_pct = 0;
        stall_pct = 0;
        set_pct = 50;
        long_delays = 0;
        calm = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gap_pct = 25;
        stall_pct = 25;
        send_word(CMD_SET, '0, 16'hFFFF);          // zero delay fires on next tick
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_TICK, '1, '1);               // quiet tick
        send_word(CMD_SET, {DELAY_W{1'b1}}, '0);   // far deadline, stays queued
        send_word(CMD_SET, DELAY_W'(2), 16'h0A0A);
        send_word(CMD_SET, DELAY_W'(2), 16'h0B0B); // tie: must follow 0A0A
        send_word(CMD_SET, DELAY_W'(1), 16'h0C0C);
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_TICK, '0, '0);
        for (int k = 0; k < 15; k++)
            send_word(CMD_SET, '0, TAG_W'(16'h5500 + k));
        send_word(CMD_SET, DELAY_W'(3), 16'h1234); // queue full, dropped
        send_word(CMD_TICK, '0, '0);               // fifteen expiries in one tick
        drain();

        for (int k = 0; k < 230; k++)
        begin
            if (k % 40 == 0) begin
                sel = $urandom_range(3);
                gap_pct = (sel == 0) ? 0 : 10 * sel;
                sel = $urandom_range(3);
                stall_pct = (sel == 0) ? 0 : 15 * sel;
                set_pct = 30 + $urandom_range(45);
            end
            if (k == 115)
                drain();
            if (k >= 190)
                calm = 1'b1;
            if ($urandom_range(99) < set_pct) begin
                sel = $urandom_range(99);
                if (sel < 3 && long_delays < 2) begin
                    d = DELAY_W'($urandom());
                    long_delays++;
                end
                else if (sel < 25) begin
                    d = DELAY_W'($urandom_range(60));
                end
                else begin
                    d = DELAY_W'($urandom_range(8));
                end
                send_word(CMD_SET, d, TAG_W'($urandom()));
            end
            else begin
                send_word(CMD_TICK, DELAY_W'($urandom()), TAG_W'($urandom()));
            end
        end
        in_valid <= 1'b0;

        while (awaited != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_count == 0 && awaited == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
